// File: rtl/bra_pkg.sv
// ----------------------------------------------------------------------------
// bra_pkg
// Shared constants, codes and controller/datapath interface types of the
// bitmap run allocator.
// ----------------------------------------------------------------------------
package bra_pkg;

  localparam int NUM_UNITS  = 1024;
  localparam int UNIT_SHIFT = 12;

  localparam int ADDR_W  = 64;
  localparam int SIZE_W  = 32;
  localparam int UNITS_W = 11;
  localparam int COUNT_W = 11;

  localparam int UIDX_W    = $clog2(NUM_UNITS);
  localparam int CNT_W     = UIDX_W + 1;
  localparam int WORD_W    = (NUM_UNITS >= 64) ? 32 : NUM_UNITS / 2;
  localparam int BIT_W     = $clog2(WORD_W);
  localparam int NUM_WORDS = NUM_UNITS / WORD_W;
  localparam int WADDR_W   = $clog2(NUM_WORDS);
  localparam int REQ_W     = SIZE_W + 1 - UNIT_SHIFT;

  localparam logic [SIZE_W:0] UNIT_MASK =
    (SIZE_W + 1)'((64'd1 << UNIT_SHIFT) - 64'd1);

  localparam int APB_AW = 4;
  localparam int APB_DW = 64;
  localparam logic REG_BASE  = 1'b0;
  localparam logic REG_UNITS = 1'b1;
  localparam logic [UNITS_W-1:0] UNITS_RESET = UNITS_W'(1024);

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_NO_MEM  = 2'd1,
    STAT_BAD_PTR = 2'd2,
    STAT_BAD_REC = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    FIN_NONE,
    FIN_ALLOC,
    FIN_FREE
  } fin_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_ALLOC_CHK,
    S_SCAN,
    S_FREE_CHK,
    S_FREE_REC,
    S_MARK_INIT,
    S_MARK
  } state_t;

  typedef struct packed {
    logic    clr_step;
    logic    load;
    logic    scan_init;
    logic    scan_step;
    logic    free_rd;
    logic    rec_load;
    logic    mark_init;
    logic    mark_step;
    logic    finish;
    fin_t    fin_kind;
    status_t fin_status;
  } dp_cmd_t;

  typedef struct packed {
    logic clr_done;
    logic is_free;
    logic req_zero;
    logic req_big;
    logic scan_found;
    logic scan_fail;
    logic addr_zero;
    logic ptr_bad;
    logic rec_zero;
    logic rec_bad;
    logic mark_done;
  } dp_stat_t;

endpackage

// File: rtl/bitmap_run_allocator_unit.sv
// ----------------------------------------------------------------------------
// bitmap_run_allocator_unit
// First-fit allocator over a pool of equal units, one used bit per unit
// and a run-length record per start unit.
//
// Requests: start is taken when busy is low; in_action selects allocate (0,
// in_size_bytes rounded up to units) or free (1, in_address). Each request
// gives one result, shown for one cycle with out_strobe; the receiver has no
// back-pressure and must take it then.
// Configuration over APB: base address at 0x0, pool size at 0x8 (64-bit
// data); write only while no request is in flight.
// Timing: the used map is walked one 32-unit word per cycle through its RAM.
// Allocate scans words up to the first fit and then marks the words of the
// run; free fetches the run-length record and then clears the words of the
// run; an allocate whose scan finds no fit ends after the last pool word,
// and other rejected or no-op requests end after their check.
// One transaction is in flight at a time; the next start is taken in the
// cycle that shows the strobe.
// Reset: a clearing pass zeroes both RAMs with busy high; the registers
// return to base 0 and pool size 1024.
// ----------------------------------------------------------------------------
module bitmap_run_allocator_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic                        in_action,
  input  logic [bra_pkg::SIZE_W-1:0]  in_size_bytes,
  input  logic [bra_pkg::ADDR_W-1:0]  in_address,
  output logic                        out_strobe,
  output logic [bra_pkg::ADDR_W-1:0]  out_result_address,
  output logic [1:0]                  out_status,
  output logic [bra_pkg::COUNT_W-1:0] out_unit_count,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [bra_pkg::APB_AW-1:0]  paddr,
  input  logic [bra_pkg::APB_DW-1:0]  pwdata,
  output logic [bra_pkg::APB_DW-1:0]  prdata,
  output logic                        pready
);
  import bra_pkg::*;

  logic [ADDR_W-1:0] base;
  logic [CNT_W-1:0]  pool_n;
  dp_cmd_t           cmd;
  dp_stat_t          stat;
  status_t           status;

  bra_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .base    (base),
    .pool_n  (pool_n)
  );

  bra_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .action (in_action),
    .stat   (stat),
    .cmd    (cmd),
    .busy   (busy)
  );

  bra_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .stat               (stat),
    .in_action          (in_action),
    .in_size_bytes      (in_size_bytes),
    .in_address         (in_address),
    .base               (base),
    .pool_n             (pool_n),
    .out_strobe         (out_strobe),
    .out_result_address (out_result_address),
    .out_status         (status),
    .out_unit_count     (out_unit_count)
  );

  assign out_status = status;

endmodule

// File: rtl/bra_ram.sv
// ----------------------------------------------------------------------------
// bra_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data.
// ----------------------------------------------------------------------------
module bra_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/bra_cfg.sv
// ----------------------------------------------------------------------------
// bra_cfg
// APB register file: pool base address and pool size, with the pool size
// saturated to the number of units the allocator holds.
// ----------------------------------------------------------------------------
module bra_cfg (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [bra_pkg::APB_AW-1:0] paddr,
  input  logic [bra_pkg::APB_DW-1:0] pwdata,
  output logic [bra_pkg::APB_DW-1:0] prdata,
  output logic                       pready,
  output logic [bra_pkg::ADDR_W-1:0] base,
  output logic [bra_pkg::CNT_W-1:0]  pool_n
);
  import bra_pkg::*;

  localparam int SAT_W = (CNT_W > UNITS_W) ? CNT_W : UNITS_W;

  logic [ADDR_W-1:0]  base_r;
  logic [UNITS_W-1:0] units_r;
  logic               wr_en;
  logic               reg_sel;
  logic [SAT_W-1:0]   units_ext;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_sel = paddr[APB_AW-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r  <= '0;
      units_r <= UNITS_RESET;
    end else if (wr_en) begin
      case (reg_sel)
        REG_BASE:  base_r  <= pwdata[ADDR_W-1:0];
        REG_UNITS: units_r <= pwdata[UNITS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_BASE:  prdata = base_r;
      REG_UNITS: prdata = APB_DW'(units_r);
      default:   prdata = '0;
    endcase
  end

  assign units_ext = SAT_W'(units_r);
  assign base      = base_r;
  assign pool_n    = (units_ext > SAT_W'(NUM_UNITS)) ? CNT_W'(NUM_UNITS)
                                                     : CNT_W'(units_ext);

endmodule

// File: rtl/bra_ctrl.sv
// ----------------------------------------------------------------------------
// bra_ctrl
// Request sequencer: clearing pass after reset, allocate check and scan,
// free check and record fetch, run marking, result issue.
// ----------------------------------------------------------------------------
module bra_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              action,
  input  bra_pkg::dp_stat_t stat,
  output bra_pkg::dp_cmd_t  cmd,
  output logic              busy
);
  import bra_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: begin
        if (stat.clr_done) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (start) state_nxt = action ? S_FREE_CHK : S_ALLOC_CHK;
      end
      S_ALLOC_CHK: begin
        state_nxt = (stat.req_zero || stat.req_big) ? S_IDLE : S_SCAN;
      end
      S_SCAN: begin
        if (stat.scan_found) state_nxt = S_MARK_INIT;
        else if (stat.scan_fail) state_nxt = S_IDLE;
      end
      S_FREE_CHK: begin
        state_nxt = (stat.addr_zero || stat.ptr_bad) ? S_IDLE : S_FREE_REC;
      end
      S_FREE_REC: begin
        state_nxt = (stat.rec_zero || stat.rec_bad) ? S_IDLE : S_MARK_INIT;
      end
      S_MARK_INIT: begin
        state_nxt = S_MARK;
      end
      S_MARK: begin
        if (stat.mark_done) state_nxt = S_IDLE;
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  always_comb begin
    cmd            = '0;
    cmd.fin_kind   = FIN_NONE;
    cmd.fin_status = STAT_OK;
    case (state_r)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
      end
      S_IDLE: begin
        cmd.load = start;
      end
      S_ALLOC_CHK: begin
        if (stat.req_zero) begin
          cmd.finish = 1'b1;
        end else if (stat.req_big) begin
          cmd.finish     = 1'b1;
          cmd.fin_status = STAT_NO_MEM;
        end else begin
          cmd.scan_init = 1'b1;
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (!stat.scan_found && stat.scan_fail) begin
          cmd.finish     = 1'b1;
          cmd.fin_status = STAT_NO_MEM;
        end
      end
      S_FREE_CHK: begin
        if (stat.addr_zero) begin
          cmd.finish = 1'b1;
        end else if (stat.ptr_bad) begin
          cmd.finish     = 1'b1;
          cmd.fin_status = STAT_BAD_PTR;
        end else begin
          cmd.free_rd = 1'b1;
        end
      end
      S_FREE_REC: begin
        if (stat.rec_zero) begin
          cmd.finish = 1'b1;
        end else if (stat.rec_bad) begin
          cmd.finish     = 1'b1;
          cmd.fin_status = STAT_BAD_REC;
        end else begin
          cmd.rec_load = 1'b1;
        end
      end
      S_MARK_INIT: begin
        cmd.mark_init = 1'b1;
      end
      S_MARK: begin
        cmd.mark_step = 1'b1;
        if (stat.mark_done) begin
          cmd.finish   = 1'b1;
          cmd.fin_kind = stat.is_free ? FIN_FREE : FIN_ALLOC;
        end
      end
      default: ;
    endcase
  end

endmodule

// File: rtl/bra_dp.sv
// ----------------------------------------------------------------------------
// bra_dp
// Allocator datapath: used-bit map and run-length table RAMs, word-wide
// first-fit scan, run set/clear read-modify-write, pointer checks and
// result registers.
// ----------------------------------------------------------------------------
module bra_dp (
  input  logic                       clk,
  input  logic                       rst_n,
  input  bra_pkg::dp_cmd_t           cmd,
  output bra_pkg::dp_stat_t          stat,
  input  logic                       in_action,
  input  logic [bra_pkg::SIZE_W-1:0] in_size_bytes,
  input  logic [bra_pkg::ADDR_W-1:0] in_address,
  input  logic [bra_pkg::ADDR_W-1:0] base,
  input  logic [bra_pkg::CNT_W-1:0]  pool_n,
  output logic                       out_strobe,
  output logic [bra_pkg::ADDR_W-1:0] out_result_address,
  output bra_pkg::status_t           out_status,
  output logic [bra_pkg::COUNT_W-1:0] out_unit_count
);
  import bra_pkg::*;

  localparam int CMP_W = (REQ_W > CNT_W) ? REQ_W : CNT_W;

  // request
  logic              action_r;
  logic [REQ_W-1:0]  req_r, req_nxt;
  logic [ADDR_W-1:0] addr_r;
  logic [SIZE_W:0]   size_sum;

  // clearing pass
  logic [UIDX_W-1:0] clr_cnt_r, clr_cnt_nxt;

  // word walk
  logic [WADDR_W:0]   wa_r, wa_nxt;
  logic [WADDR_W-1:0] lim_w_r, lim_w_nxt;
  logic               dv_r, dv_nxt;
  logic [WADDR_W-1:0] dw_r, dw_nxt;
  logic [CNT_W-1:0]   run_r, run_nxt;

  // run under work
  logic [UIDX_W-1:0] idx_r, idx_nxt;
  logic [UIDX_W-1:0] first_r, first_nxt;
  logic [CNT_W-1:0]  len_r, len_nxt;
  logic [CNT_W-1:0]  unit_end;
  logic [CNT_W-1:0]  unit_last;
  logic [CNT_W-1:0]  pool_last;

  // results
  logic               strobe_r;
  logic [ADDR_W-1:0]  res_addr_r;
  status_t            status_r;
  logic [COUNT_W-1:0] count_r;

  // RAM ports
  logic               used_we;
  logic [WADDR_W-1:0] used_waddr;
  logic [WORD_W-1:0]  used_wdata;
  logic [WORD_W-1:0]  used_q;
  logic               tab_we;
  logic [UIDX_W-1:0]  tab_waddr;
  logic [CNT_W-1:0]   tab_wdata;
  logic [CNT_W-1:0]   tab_q;

  // scan / mark
  logic [WORD_W-1:0] occ;
  logic [CNT_W-1:0]  run_v [WORD_W];
  logic [WORD_W-1:0] hit;
  logic              scan_hit;
  logic [BIT_W-1:0]  scan_pos;
  logic [CNT_W-1:0]  req_c;
  logic [CNT_W-1:0]  scan_start;
  logic [WORD_W-1:0] mark_mask;

  // free checks
  logic [ADDR_W-1:0] off;
  logic [UIDX_W-1:0] off_idx;
  logic [CNT_W-1:0]  room;

  bra_ram #(.WIDTH(WORD_W), .DEPTH(NUM_WORDS)) u_used_ram (
    .clk   (clk),
    .we    (used_we),
    .waddr (used_waddr),
    .wdata (used_wdata),
    .raddr (wa_r[WADDR_W-1:0]),
    .rdata (used_q)
  );

  bra_ram #(.WIDTH(CNT_W), .DEPTH(NUM_UNITS)) u_len_ram (
    .clk   (clk),
    .we    (tab_we),
    .waddr (tab_waddr),
    .wdata (tab_wdata),
    .raddr (off_idx),
    .rdata (tab_q)
  );

  assign size_sum  = {1'b0, in_size_bytes} + UNIT_MASK;
  assign req_nxt   = size_sum[SIZE_W:UNIT_SHIFT];
  assign req_c     = CNT_W'(req_r);
  assign pool_last = pool_n - 1'b1;
  assign unit_end  = {1'b0, first_r} + len_r;
  assign unit_last = unit_end - 1'b1;

  assign off     = addr_r - base;
  assign off_idx = off[UNIT_SHIFT+UIDX_W-1:UNIT_SHIFT];
  assign room    = pool_n - {1'b0, idx_r};

  // first-fit evaluation of the word returned by the used RAM
  always_comb begin : scan_eval
    logic             seen;
    logic [BIT_W-1:0] lpos;
    logic [UIDX_W-1:0] ub;
    seen = 1'b0;
    lpos = '0;
    ub   = '0;
    for (int b = 0; b < WORD_W; b++) begin
      ub     = {dw_r, BIT_W'(b)};
      occ[b] = used_q[b] | ({1'b0, ub} >= pool_n);
    end
    for (int b = 0; b < WORD_W; b++) begin
      seen = 1'b0;
      lpos = '0;
      for (int j = 0; j <= b; j++) begin
        if (occ[j]) begin
          seen = 1'b1;
          lpos = BIT_W'(j);
        end
      end
      run_v[b] = seen ? CNT_W'(BIT_W'(b) - lpos) : run_r + CNT_W'(b + 1);
      hit[b]   = (run_v[b] >= req_c);
    end
    scan_hit = 1'b0;
    scan_pos = '0;
    for (int b = WORD_W - 1; b >= 0; b--) begin
      if (hit[b]) begin
        scan_hit = 1'b1;
        scan_pos = BIT_W'(b);
      end
    end
  end

  assign scan_start = {1'b0, dw_r, scan_pos} + CNT_W'(1) - req_c;

  always_comb begin : mask_gen
    logic [UIDX_W-1:0] ub;
    ub = '0;
    for (int b = 0; b < WORD_W; b++) begin
      ub           = {dw_r, BIT_W'(b)};
      mark_mask[b] = (ub >= first_r) && ({1'b0, ub} < unit_end);
    end
  end

  // RAM writes
  always_comb begin
    used_we    = 1'b0;
    used_waddr = dw_r;
    used_wdata = action_r ? (used_q & ~mark_mask) : (used_q | mark_mask);
    tab_we     = 1'b0;
    tab_waddr  = first_r;
    tab_wdata  = action_r ? '0 : len_r;
    if (cmd.clr_step) begin
      used_we    = 1'b1;
      used_waddr = clr_cnt_r[UIDX_W-1:BIT_W];
      used_wdata = '0;
      tab_we     = 1'b1;
      tab_waddr  = clr_cnt_r;
      tab_wdata  = '0;
    end else begin
      used_we = cmd.mark_step & dv_r;
      tab_we  = cmd.mark_init;
    end
  end

  // sequencing registers
  always_comb begin
    clr_cnt_nxt = cmd.clr_step ? clr_cnt_r + 1'b1 : clr_cnt_r;
    wa_nxt      = wa_r;
    lim_w_nxt   = lim_w_r;
    dv_nxt      = 1'b0;
    dw_nxt      = dw_r;
    run_nxt     = run_r;
    idx_nxt     = idx_r;
    first_nxt   = first_r;
    len_nxt     = len_r;
    if (cmd.scan_init) begin
      wa_nxt    = '0;
      lim_w_nxt = pool_last[UIDX_W-1:BIT_W];
      run_nxt   = '0;
    end else if (cmd.mark_init) begin
      wa_nxt    = {1'b0, first_r[UIDX_W-1:BIT_W]};
      lim_w_nxt = unit_last[UIDX_W-1:BIT_W];
    end else if ((cmd.scan_step || cmd.mark_step) && (wa_r <= {1'b0, lim_w_r})) begin
      dv_nxt = 1'b1;
      dw_nxt = wa_r[WADDR_W-1:0];
      wa_nxt = wa_r + 1'b1;
    end
    if (cmd.scan_step && dv_r) begin
      if (scan_hit) begin
        first_nxt = scan_start[UIDX_W-1:0];
        len_nxt   = req_c;
      end else begin
        run_nxt = run_v[WORD_W-1];
      end
    end
    if (cmd.free_rd) begin
      idx_nxt = off_idx;
    end
    if (cmd.rec_load) begin
      first_nxt = idx_r;
      len_nxt   = tab_q;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
      dv_r      <= 1'b0;
      strobe_r  <= 1'b0;
    end else begin
      clr_cnt_r <= clr_cnt_nxt;
      dv_r      <= dv_nxt;
      strobe_r  <= cmd.finish;
    end
  end

  always_ff @(posedge clk) begin
    wa_r    <= wa_nxt;
    lim_w_r <= lim_w_nxt;
    dw_r    <= dw_nxt;
    run_r   <= run_nxt;
    idx_r   <= idx_nxt;
    first_r <= first_nxt;
    len_r   <= len_nxt;
    if (cmd.load) begin
      action_r <= in_action;
      req_r    <= req_nxt;
      addr_r   <= in_address;
    end
    if (cmd.finish) begin
      status_r   <= cmd.fin_status;
      res_addr_r <= (cmd.fin_kind == FIN_ALLOC) ?
                    base + (ADDR_W'(first_r) << UNIT_SHIFT) : '0;
      count_r    <= (cmd.fin_kind == FIN_NONE) ? '0 : COUNT_W'(len_r);
    end
  end

  always_comb begin
    stat            = '0;
    stat.clr_done   = (clr_cnt_r == '1);
    stat.is_free    = action_r;
    stat.req_zero   = (req_r == '0);
    stat.req_big    = (CMP_W'(req_r) > CMP_W'(pool_n));
    stat.scan_found = dv_r & scan_hit;
    stat.scan_fail  = dv_r & ~scan_hit & (dw_r == lim_w_r);
    stat.addr_zero  = (addr_r == '0);
    stat.ptr_bad    = (|off[ADDR_W-1:UNIT_SHIFT+UIDX_W]) || ({1'b0, off_idx} >= pool_n);
    stat.rec_zero   = (tab_q == '0);
    stat.rec_bad    = (tab_q > room);
    stat.mark_done  = dv_r & (dw_r == lim_w_r);
  end

  assign out_strobe         = strobe_r;
  assign out_result_address = res_addr_r;
  assign out_status         = status_r;
  assign out_unit_count     = count_r;

endmodule

// File: rtl/bra_chk.sv
// ----------------------------------------------------------------------------
// bra_chk
// Port-level checks of the allocator: request/result sequencing and result
// field consistency.
// ----------------------------------------------------------------------------
module bra_chk (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        start,
  input logic                        busy,
  input logic                        out_strobe,
  input logic [bra_pkg::ADDR_W-1:0]  out_result_address,
  input logic [1:0]                  out_status,
  input logic [bra_pkg::COUNT_W-1:0] out_unit_count
);
  import bra_pkg::*;

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted transaction did not raise busy");

  a_result_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(busy))
    else $error("result without a transaction in flight");

  a_strobe_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe)
    else $error("back-to-back result strobes");

  a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && (out_status != STAT_OK) |->
      (out_result_address == '0) && (out_unit_count == '0))
    else $error("failed transaction reported address or count");

  a_nocount_noaddr: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && (out_unit_count == '0) |-> (out_result_address == '0))
    else $error("address reported with zero unit count");

endmodule

bind bitmap_run_allocator_unit bra_chk u_bra_chk (.*);

// File: tb/sv/bitmap_run_allocator_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_run_allocator_unit_tb
// Self-checking bench for the first-fit bitmap allocator. A short stimulus
// table exercises the size and address extremes, the error codes and the
// pool size register; random allocate/free traffic then runs in four phases
// with different pool settings and request spacing. Each transaction is
// predicted at acceptance and the result is checked field by field.
// ----------------------------------------------------------------------------
module bitmap_run_allocator_unit_tb;
  import bra_pkg::*;

  localparam logic ACT_ALLOC        = 1'b0;
  localparam logic ACT_FREE         = 1'b1;
  localparam int   WATCHDOG_LIMIT   = 4000;
  localparam int   DRAIN_CYCLES     = 150;
  localparam int   RANDOM_PER_PHASE = 225;

  typedef enum logic { ROW_REQUEST, ROW_CONFIG } row_kind_t;

  typedef struct packed {
    logic [ADDR_W-1:0]  addr;
    status_t            status;
    logic [COUNT_W-1:0] count;
  } outcome_t;

  typedef struct {
    row_kind_t         kind;
    logic              act;
    logic [SIZE_W-1:0] size;
    logic [ADDR_W-1:0] addr;
    bit                typed;
    outcome_t          want;
    logic              cfg_sel;
    logic [APB_DW-1:0] cfg_value;
  } stim_row_t;

  logic                clk;
  logic                rst_n;
  logic                start;
  logic                busy;
  logic                in_action;
  logic [SIZE_W-1:0]   in_size_bytes;
  logic [ADDR_W-1:0]   in_address;
  logic                out_strobe;
  logic [ADDR_W-1:0]   out_result_address;
  logic [1:0]          out_status;
  logic [COUNT_W-1:0]  out_unit_count;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [APB_AW-1:0]   paddr;
  logic [APB_DW-1:0]   pwdata;
  logic [APB_DW-1:0]   prdata;
  logic                pready;

  // allocator shadow state
  bit                  unit_taken [NUM_UNITS];
  bit [COUNT_W-1:0]    run_len_at [NUM_UNITS];
  logic [ADDR_W-1:0]   pool_base      = '0;
  logic [UNITS_W-1:0]  pool_units_reg = UNITS_RESET;

  outcome_t            pending_outcomes [$];
  int unsigned         live_units [$];
  stim_row_t           directed_rows [$];
  int                  mismatches  = 0;
  int                  idle_cycles = 0;

  bitmap_run_allocator_unit DUT (.*);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic outcome_t serve_request(logic act, logic [SIZE_W-1:0] sz,
                                             logic [ADDR_W-1:0] ad);
    outcome_t        o;
    int unsigned     pool;
    int unsigned     run;
    int unsigned     first;
    int unsigned     rec;
    longint unsigned need;
    longint unsigned idx;
    bit              found;
    o.addr   = '0;
    o.status = STAT_OK;
    o.count  = '0;
    pool  = (pool_units_reg > NUM_UNITS) ? NUM_UNITS : pool_units_reg;
    found = 1'b0;
    first = 0;
    run   = 0;
    if (act == ACT_ALLOC) begin
      need = 64'(sz) >> UNIT_SHIFT;
      if ((64'(sz) & ((64'd1 << UNIT_SHIFT) - 64'd1)) != 0) need++;
      if (need != 0) begin
        if (need <= pool) begin
          for (int u = 0; u < pool; u++) begin
            if (unit_taken[u]) begin
              run = 0;
            end else begin
              run++;
              if (run == need) begin
                first = u + 1 - run;
                found = 1'b1;
                break;
              end
            end
          end
        end
        if (found) begin
          for (int k = 0; k < need; k++) unit_taken[first + k] = 1'b1;
          run_len_at[first] = COUNT_W'(need);
          o.addr  = pool_base + (64'(first) << UNIT_SHIFT);
          o.count = COUNT_W'(need);
        end else begin
          o.status = STAT_NO_MEM;
        end
      end
    end else if (ad != 0) begin
      idx = (ad - pool_base) >> UNIT_SHIFT;
      if (idx >= pool) begin
        o.status = STAT_BAD_PTR;
      end else begin
        rec = run_len_at[idx];
        if (rec != 0) begin
          if (rec > pool - idx) begin
            o.status = STAT_BAD_REC;
          end else begin
            for (int k = 0; k < rec; k++) unit_taken[idx + k] = 1'b0;
            run_len_at[idx] = '0;
            o.count = COUNT_W'(rec);
          end
        end
      end
    end
    return o;
  endfunction

  function automatic void check_field(string what, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t  %s mismatch: expected %0h, got %0h", $time, what, want, got);
    end
  endfunction

  function automatic void add_req(logic act, logic [SIZE_W-1:0] sz, logic [ADDR_W-1:0] ad);
    stim_row_t r;
    r.kind  = ROW_REQUEST;
    r.act   = act;
    r.size  = sz;
    r.addr  = ad;
    r.typed = 1'b0;
    directed_rows.push_back(r);
  endfunction

  function automatic void add_checked(logic act, logic [SIZE_W-1:0] sz,
                                      logic [ADDR_W-1:0] ad, logic [ADDR_W-1:0] e_addr,
                                      status_t e_status, logic [COUNT_W-1:0] e_count);
    add_req(act, sz, ad);
    directed_rows[$].typed       = 1'b1;
    directed_rows[$].want.addr   = e_addr;
    directed_rows[$].want.status = e_status;
    directed_rows[$].want.count  = e_count;
  endfunction

  function automatic void add_cfg(logic sel, logic [APB_DW-1:0] value);
    stim_row_t r;
    r.kind      = ROW_CONFIG;
    r.cfg_sel   = sel;
    r.cfg_value = value;
    directed_rows.push_back(r);
  endfunction

  // entered and left just after a falling edge; start stays high on return
  task automatic send_request(input stim_row_t row, input int idle_pct);
    outcome_t got;
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start         <= 1'b1;
    in_action     <= row.act;
    in_size_bytes <= row.size;
    in_address    <= row.addr;
    do @(posedge clk); while (busy);
    got = serve_request(row.act, row.size, row.addr);
    if (row.act == ACT_ALLOC && got.status == STAT_OK && got.count != 0)
      live_units.push_back(int'((got.addr - pool_base) >> UNIT_SHIFT));
    pending_outcomes.push_back(row.typed ? row.want : got);
    @(negedge clk);
  endtask

  task automatic write_register(input logic sel, input logic [APB_DW-1:0] value);
    start <= 1'b0;
    while (pending_outcomes.size() != 0 || busy) @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {sel, 3'b000};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (sel == REG_BASE) pool_base = value;
    else                 pool_units_reg = value[UNITS_W-1:0];
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  always @(posedge clk) begin
    outcome_t want;
    if (rst_n && out_strobe === 1'b1) begin
      if (pending_outcomes.size() == 0) begin
        mismatches++;
        $display("%0t  unexpected result: addr %0h status %0d count %0d", $time,
                 out_result_address, out_status, out_unit_count);
      end else begin
        want = pending_outcomes.pop_front();
        check_field("result_address", want.addr, out_result_address);
        check_field("status", 64'(want.status), 64'(out_status));
        check_field("unit_count", 64'(want.count), 64'(out_unit_count));
      end
    end
  end

  always @(posedge clk) begin
    if ((start && !busy) || out_strobe || (psel && penable && pwrite && pready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    stim_row_t         row;
    int                pick;
    int                span;
    int                k;
    int                idle_pct;
    logic [APB_DW-1:0] base_val;
    logic [APB_DW-1:0] units_val;

    rst_n         = 1'b0;
    start         = 1'b0;
    in_action     = ACT_ALLOC;
    in_size_bytes = '0;
    in_address    = '0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;

    // pool of 1024 units, base 0
    add_checked(ACT_ALLOC, 32'd0,          64'd0, 64'd0,    STAT_OK,     11'd0);
    add_checked(ACT_ALLOC, 32'hFFFF_FFFF,  64'd0, 64'd0,    STAT_NO_MEM, 11'd0);
    add_checked(ACT_ALLOC, 32'd1,          64'd0, 64'd0,    STAT_OK,     11'd1);
    add_checked(ACT_ALLOC, 32'd4096,       64'd0, 64'h1000, STAT_OK,     11'd1);
    add_checked(ACT_ALLOC, 32'd4097,       64'd0, 64'h2000, STAT_OK,     11'd2);
    add_checked(ACT_FREE,  32'hFFFF_FFFF,  64'd0,      64'd0, STAT_OK,   11'd0);
    add_checked(ACT_FREE,  32'd0,          64'h1000,   64'd0, STAT_OK,   11'd1);
    add_checked(ACT_FREE,  32'd0,          64'h1000,   64'd0, STAT_OK,   11'd0);
    add_checked(ACT_FREE,  32'd0,          64'h2FFF,   64'd0, STAT_OK,   11'd2);
    add_checked(ACT_FREE,  32'd0, 64'hFFFF_FFFF_FFFF_FFFF, 64'd0, STAT_BAD_PTR, 11'd0);
    add_checked(ACT_FREE,  32'd0,          64'h40_0000, 64'd0, STAT_BAD_PTR, 11'd0);
    add_checked(ACT_ALLOC, 32'h40_0000,    64'd0, 64'd0,    STAT_NO_MEM, 11'd0);
    add_checked(ACT_ALLOC, 32'h3F_F000,    64'd0, 64'h1000, STAT_OK,     11'd1023);
    add_checked(ACT_ALLOC, 32'd1,          64'd0, 64'd0,    STAT_NO_MEM, 11'd0);
    // shrink the pool under a live run
    add_cfg(REG_UNITS, 64'd1000);
    add_checked(ACT_FREE,  32'd0, 64'h1000,    64'd0, STAT_BAD_REC, 11'd0);
    add_checked(ACT_FREE,  32'd0, 64'h3E_8000, 64'd0, STAT_BAD_PTR, 11'd0);
    add_cfg(REG_UNITS, 64'd0);
    add_checked(ACT_ALLOC, 32'd1,  64'd0,      64'd0, STAT_NO_MEM,  11'd0);
    add_checked(ACT_FREE,  32'd0,  64'h1000,   64'd0, STAT_BAD_PTR, 11'd0);
    // above the unit count: saturates
    add_cfg(REG_UNITS, 64'd2047);
    add_checked(ACT_FREE,  32'd0,  64'h1000,   64'd0, STAT_OK,      11'd1023);
    // base near the top: addresses wrap
    add_cfg(REG_BASE, 64'hFFFF_FFFF_FFFF_F000);
    add_checked(ACT_ALLOC, 32'd4096, 64'd0, 64'd0, STAT_OK, 11'd1);
    add_checked(ACT_FREE,  32'd0, 64'hFFFF_FFFF_FFFF_F000, 64'd0, STAT_OK, 11'd1);
    add_req(ACT_FREE, 32'd0, 64'h1000);
    add_cfg(REG_UNITS, 64'd1);
    add_req(ACT_ALLOC, 32'd8192, 64'd0);
    add_req(ACT_ALLOC, 32'd1,    64'd0);

    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CONFIG)
        write_register(directed_rows[i].cfg_sel, directed_rows[i].cfg_value);
      else
        send_request(directed_rows[i], 0);
    end

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          base_val  = {$urandom, $urandom};
          units_val = 64'd1024;
          idle_pct  = 0;
        end
        1: begin
          base_val  = {$urandom, $urandom};
          units_val = 64'($urandom_range(16, NUM_UNITS));
          idle_pct  = 79;
        end
        2: begin
          base_val  = 64'hFFFF_FFFF_FFFF_FFFF;
          units_val = 64'd64;
          idle_pct  = 0;
        end
        default: begin
          base_val  = 64'd0;
          units_val = 64'd1024;
          idle_pct  = 10;
        end
      endcase
      write_register(REG_BASE, base_val);
      write_register(REG_UNITS, units_val);
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        pick      = $urandom_range(99);
        row.kind  = ROW_REQUEST;
        row.typed = 1'b0;
        row.act   = ACT_ALLOC;
        row.size  = '0;
        row.addr  = '0;
        if (pick < 45 || (pick < 85 && live_units.size() == 0)) begin
          span = ($urandom_range(9) == 0) ? $urandom_range(1, NUM_UNITS)
                                          : $urandom_range(1, 8);
          row.size = SIZE_W'((span - 1) << UNIT_SHIFT) +
                     SIZE_W'($urandom_range(1, 1 << UNIT_SHIFT));
        end else if (pick < 85) begin
          k        = $urandom_range(live_units.size() - 1);
          row.act  = ACT_FREE;
          row.addr = pool_base + (64'(live_units[k]) << UNIT_SHIFT);
          if ($urandom_range(3) == 0)
            row.addr += 64'($urandom_range((1 << UNIT_SHIFT) - 1));
          live_units.delete(k);
        end else if (pick < 90) begin
          row.act  = ACT_FREE;
          row.addr = {$urandom, $urandom};
        end else if (pick < 93) begin
          // zero size or null pointer
          row.act = ($urandom_range(1) == 0) ? ACT_ALLOC : ACT_FREE;
        end else begin
          row.size = $urandom;
        end
        send_request(row, idle_pct);
      end
    end

    start <= 1'b0;
    while (pending_outcomes.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatches == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
